### rtl/core/hcfm_pkg.sv
// ----------------------------------------------------------------------------
// hcfm_pkg
// Shared types and codes for the heartbeat channel failover monitor.
// ----------------------------------------------------------------------------
package hcfm_pkg;

   typedef enum logic [1:0] {
      AGE_SET     = 2'd0,
      AGE_RESET   = 2'd1,
      AGE_TIMEOUT = 2'd2,
      AGE_EXPIRED = 2'd3
   } age_type;

   typedef enum logic {
      REQ_HEARTBEAT = 1'b0,
      REQ_TICK      = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SELECT = 2'd1,
      EV_FAIL   = 2'd2
   } event_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_CHOOSE,
      ST_RESP
   } state_type;

   localparam int CH_W   = 3;
   localparam int MASK_W = 8;

endpackage

### rtl/core/hcfm_state_mem.sv
// ----------------------------------------------------------------------------
// hcfm_state_mem
// Per-channel age store: one write and one registered read port per cycle.
// Entries not yet written read back as SET.
// ----------------------------------------------------------------------------
module hcfm_state_mem
   import hcfm_pkg::*;
#(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  age_type           wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output age_type           rd_data
);

   age_type          mem_ff [DEPTH];
   logic [DEPTH-1:0] written_ff;
   age_type          rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= written_ff[rd_addr] ? mem_ff[rd_addr] : AGE_SET;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/hcfm_walk_ctrl.sv
// ----------------------------------------------------------------------------
// hcfm_walk_ctrl
// Request sequencer: applies heartbeats, walks the age store on a tick,
// tracks live channels and the current channel, builds the response.
// ----------------------------------------------------------------------------
module hcfm_walk_ctrl
   import hcfm_pkg::*;
#(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3,
   parameter int CNT_W  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_type,
   input  logic [CH_W-1:0]   req_channel,
   input  logic [CNT_W-1:0]  used_count,
   output logic              busy,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output age_type           mem_wr_data,
   output logic              mem_rd_en,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  age_type           mem_rd_data,
   output logic              rsp_valid,
   output logic [1:0]        rsp_event_res,
   output logic [CH_W-1:0]   rsp_event_channel,
   output logic [CH_W-1:0]   rsp_current_channel,
   output logic              rsp_current_valid,
   output logic [MASK_W-1:0] rsp_live_mask
);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic              chosen_ff, chosen_in;
   logic [DEPTH-1:0]  live_ff, live_in;
   event_type         ev_ff, ev_in;
   logic [ADDR_W-1:0] ev_ch_ff, ev_ch_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_ev_ff, rsp_ev_in;
   logic [CH_W-1:0]   rsp_ev_ch_ff, rsp_ev_ch_in;
   logic [CH_W-1:0]   rsp_cur_ff, rsp_cur_in;
   logic              rsp_cv_ff, rsp_cv_in;
   logic [MASK_W-1:0] rsp_mask_ff, rsp_mask_in;

   logic [DEPTH-1:0]        used_vec;
   logic [DEPTH-1:0]        walk_live;
   logic [DEPTH+MASK_W-1:0] mask_pad;
   age_type                 aged;
   logic                    accept;
   logic                    last;
   logic                    hb_ok;
   logic                    walk_found, idle_found;
   logic [ADDR_W-1:0]       walk_pick, idle_pick;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign last   = (32'(idx_ff) + 1 >= 32'(used_count));
   assign hb_ok  = (32'(req_channel) < 32'(used_count));

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         used_vec[i] = (i < 32'(used_count));
      end
   end

   always_comb begin
      case (mem_rd_data)
         AGE_SET:   aged = AGE_RESET;
         AGE_RESET: aged = AGE_TIMEOUT;
         default:   aged = AGE_EXPIRED;
      endcase
   end

   always_comb begin
      walk_live         = live_ff;
      walk_live[idx_ff] = (aged == AGE_SET) || (aged == AGE_RESET);
   end

   // first live channel in use, lowest index wins
   always_comb begin
      walk_found = 1'b0;
      walk_pick  = '0;
      idle_found = 1'b0;
      idle_pick  = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (walk_live[i] && used_vec[i]) begin
            walk_found = 1'b1;
            walk_pick  = ADDR_W'(i);
         end
         if (live_ff[i] && used_vec[i]) begin
            idle_found = 1'b1;
            idle_pick  = ADDR_W'(i);
         end
      end
   end

   assign mask_pad = (DEPTH + MASK_W)'(live_ff & used_vec);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_type == REQ_TICK) begin
                  state_in = (used_count == '0) ? ST_CHOOSE : ST_WALK;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_WALK: begin
            if (last) begin
               state_in = ST_CHOOSE;
            end
         end
         ST_CHOOSE: state_in = ST_RESP;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      chosen_in    = chosen_ff;
      live_in      = live_ff;
      ev_in        = ev_ff;
      ev_ch_in     = ev_ch_ff;
      rsp_valid_in = 1'b0;
      rsp_ev_in    = rsp_ev_ff;
      rsp_ev_ch_in = rsp_ev_ch_ff;
      rsp_cur_in   = rsp_cur_ff;
      rsp_cv_in    = rsp_cv_ff;
      rsp_mask_in  = rsp_mask_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_data  = aged;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ev_in    = EV_NONE;
               ev_ch_in = '0;
               idx_in   = '0;
               if (req_type == REQ_TICK) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = '0;
               end else if (hb_ok) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = ADDR_W'(req_channel);
                  mem_wr_data = AGE_SET;
                  live_in[ADDR_W'(req_channel)] = 1'b1;
               end
            end
         end
         ST_WALK: begin
            mem_wr_en = 1'b1;
            live_in   = walk_live;
            if (mem_rd_data == AGE_TIMEOUT && chosen_ff && cur_ff == idx_ff) begin
               if (walk_found) begin
                  cur_in   = walk_pick;
                  ev_in    = EV_SELECT;
                  ev_ch_in = walk_pick;
               end else begin
                  ev_in    = EV_FAIL;
                  ev_ch_in = '0;
               end
            end
            if (!last) begin
               idx_in      = idx_ff + 1'b1;
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff + 1'b1;
            end
         end
         ST_CHOOSE: begin
            if (!chosen_ff && idle_found) begin
               cur_in    = idle_pick;
               chosen_in = 1'b1;
               ev_in     = EV_SELECT;
               ev_ch_in  = idle_pick;
            end
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_ev_in    = ev_ff;
            rsp_ev_ch_in = CH_W'(ev_ch_ff);
            rsp_cur_in   = CH_W'(cur_ff);
            rsp_cv_in    = chosen_ff;
            rsp_mask_in  = mask_pad[MASK_W-1:0];
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         chosen_ff    <= 1'b0;
         live_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         chosen_ff    <= chosen_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      ev_ff        <= ev_in;
      ev_ch_ff     <= ev_ch_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_ev_ch_ff <= rsp_ev_ch_in;
      rsp_cur_ff   <= rsp_cur_in;
      rsp_cv_ff    <= rsp_cv_in;
      rsp_mask_ff  <= rsp_mask_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_res       = rsp_ev_ff;
   assign rsp_event_channel   = rsp_ev_ch_ff;
   assign rsp_current_channel = rsp_cur_ff;
   assign rsp_current_valid   = rsp_cv_ff;
   assign rsp_live_mask       = rsp_mask_ff;

endmodule

### rtl/core/heartbeat_channel_failover_monitor_top.sv
// Heartbeat request: IDLE, RESP, registered response strobe. Check tick: IDLE,
//   WALK one entry per cycle over the channels in use (if any), CHOOSE, RESP, strobe.
// Throughput: one request per response; busy is high from acceptance until the strobe.
// The response strobe lasts one cycle and cannot be stalled by the receiver.
// Synchronous reset: all channels SET, no current channel, channels in use = 8.
// ----------------------------------------------------------------------------
// heartbeat_channel_failover_monitor_top
// Heartbeat ageing per channel with failover of the current channel.
// ----------------------------------------------------------------------------
module heartbeat_channel_failover_monitor_top
   import hcfm_pkg::*;
#(
   parameter int MAX_CHANNELS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_type,
   input  logic [CH_W-1:0]   req_channel,
   input  logic              csr_wr_en,
   input  logic [3:0]        csr_channels_in_use,
   output logic              rsp_valid,
   output logic [1:0]        rsp_event_res,
   output logic [CH_W-1:0]   rsp_event_channel,
   output logic [CH_W-1:0]   rsp_current_channel,
   output logic              rsp_current_valid,
   output logic [MASK_W-1:0] rsp_live_mask
);

   localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);

   logic [3:0]        csr_ff;
   logic [CNT_W-1:0]  used_count;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   age_type           mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   age_type           mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= 4'd8;
      end else if (csr_wr_en) begin
         csr_ff <= csr_channels_in_use;
      end
   end

   always_comb begin
      if (32'(csr_ff) > MAX_CHANNELS) begin
         used_count = CNT_W'(MAX_CHANNELS);
      end else begin
         used_count = CNT_W'(csr_ff);
      end
   end

   hcfm_state_mem #(
      .DEPTH  (MAX_CHANNELS),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   hcfm_walk_ctrl #(
      .DEPTH  (MAX_CHANNELS),
      .ADDR_W (ADDR_W),
      .CNT_W  (CNT_W)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .req_type            (req_type),
      .req_channel         (req_channel),
      .used_count          (used_count),
      .busy                (busy),
      .mem_wr_en           (mem_wr_en),
      .mem_wr_addr         (mem_wr_addr),
      .mem_wr_data         (mem_wr_data),
      .mem_rd_en           (mem_rd_en),
      .mem_rd_addr         (mem_rd_addr),
      .mem_rd_data         (mem_rd_data),
      .rsp_valid           (rsp_valid),
      .rsp_event_res       (rsp_event_res),
      .rsp_event_channel   (rsp_event_channel),
      .rsp_current_channel (rsp_current_channel),
      .rsp_current_valid   (rsp_current_valid),
      .rsp_live_mask       (rsp_live_mask)
   );

endmodule
